// ===== rtl/core/mabt_pkg.sv =====
`default_nettype none
package mabt_pkg;

    // Operation codes carried in the input tuser
    typedef enum logic [2:0] {
        OP_ADD_ID  = 3'd0,
        OP_ADD_AD  = 3'd1,
        OP_LIFT_ID = 3'd2,
        OP_LIFT_AD = 3'd3,
        OP_SWEEP   = 3'd4,
        OP_QRY_ID  = 3'd5,
        OP_QRY_AD  = 3'd6,
        OP_CLEAR   = 3'd7
    } t_op;

    // Result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOMATCH = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam int IN_DATA_W  = 432;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 96;

    // Latched operation, with IPv4 fields already reduced to 32 bits
    typedef struct packed {
        t_op          op;
        logic [62:0]  now;
        logic [63:0]  ban_end;
        logic [31:0]  acct;
        logic         v6;
        logic [63:0]  qhi;
        logic [63:0]  qlo;
        logic [63:0]  mhi;
        logic [63:0]  mlo;
        logic [15:0]  tag;
    } t_query;

    typedef struct packed {
        logic [31:0]  value;
        logic [63:0]  expiry;
        logic [15:0]  reason;
        logic [31:0]  order;
    } t_id_ent;

    typedef struct packed {
        logic         family;
        logic [63:0]  ahi;
        logic [63:0]  alo;
        logic [63:0]  mhi;
        logic [63:0]  mlo;
        logic [63:0]  expiry;
        logic [15:0]  reason;
        logic [31:0]  order;
    } t_ad_ent;

    // Per-entry verdict of the compare unit
    typedef struct packed {
        logic stale;
        logic lift_hit;
        logic query_hit;
        logic older;
    } t_eval;

    localparam int ID_ENT_W = $bits(t_id_ent);
    localparam int AD_ENT_W = $bits(t_ad_ent);

endpackage
`default_nettype wire

// ===== rtl/core/masked_address_ban_table_unit.sv =====
`default_nettype none
// Insert, lift and query scan the table of their operation, sweep scans the ID
// table and then the address table, and clear needs no scan; an insert stops at the
// first free slot. The result is offered once the scan has finished.
// Throughput: one operation at a time, the next transfer can be taken the cycle after
// the result transfer; the entry scan reads one slot a cycle from the table memory
// through the shared compare unit.
// Reset (i_rst_n low, synchronous): both tables empty, stamp zero, block idle.
module masked_address_ban_table_unit #(
    parameter int ID_ENTRIES   = 64,
    parameter int ADDR_ENTRIES = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // current_time, ban end time, account_id, addr_high, addr_low, mask_high,
    // mask_low, reason_tag, zero pad
    input  wire logic [mabt_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // operation, is_v6
    input  wire logic [mabt_pkg::IN_USER_W-1:0]    i_s_tuser,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // status, banned, ban_until, hit_reason, removed_count, zero pad
    output logic [mabt_pkg::OUT_DATA_W-1:0]        o_m_tdata
);
    import mabt_pkg::*;

    localparam int ID_AW  = (ID_ENTRIES > 1)   ? $clog2(ID_ENTRIES)   : 1;
    localparam int AD_AW  = (ADDR_ENTRIES > 1) ? $clog2(ADDR_ENTRIES) : 1;
    localparam int IW     = (ID_AW > AD_AW) ? ID_AW : AD_AW;
    localparam logic [IW-1:0] LAST_ID = IW'(ID_ENTRIES - 1);
    localparam logic [IW-1:0] LAST_AD = IW'(ADDR_ENTRIES - 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} t_state;

    t_state            r_state;
    t_query            r_q;
    logic [IW-1:0]     r_idx, r_pidx;
    logic              r_tab, r_ptab, r_iss_done, r_pv;
    logic [ID_ENTRIES-1:0]   r_idv;
    logic [ADDR_ENTRIES-1:0] r_adv;
    logic [31:0]       r_stamp, r_best;
    logic [7:0]        r_rm;
    logic              r_match, r_found;
    logic [63:0]       r_until;
    logic [15:0]       r_reason;
    logic [1:0]        r_o_status;
    logic              r_o_banned;
    logic [63:0]       r_o_until;
    logic [15:0]       r_o_reason;
    logic [7:0]        r_o_rm;

    t_query            in_q;
    t_op               in_op;
    logic              in_v6;
    t_id_ent           id_rd, id_wr;
    t_ad_ent           ad_rd, ad_wr;
    logic [ID_ENT_W-1:0] id_rd_w;
    logic [AD_ENT_W-1:0] ad_rd_w;
    t_eval             ev;
    logic              p_valid, p_last, p_insert, p_remove, p_record, fin;
    logic              id_we, ad_we;
    logic [7:0]        n_rm;
    logic              n_match, n_found;
    logic [31:0]       n_best;
    logic [63:0]       n_until;
    logic [15:0]       n_reason;
    logic [1:0]        n_status;

    // Unpack the input transfer; IPv4 keeps only the low 32 bits
    assign in_op = t_op'(i_s_tuser[2:0]);
    assign in_v6 = i_s_tuser[3];
    always_comb begin
        in_q.op       = in_op;
        in_q.now      = i_s_tdata[62:0];
        in_q.ban_end  = i_s_tdata[126:63];
        in_q.acct     = i_s_tdata[158:127];
        in_q.v6       = in_v6;
        in_q.qhi      = in_v6 ? i_s_tdata[222:159] : 64'd0;
        in_q.qlo      = in_v6 ? i_s_tdata[286:223] : {32'd0, i_s_tdata[254:223]};
        in_q.mhi      = in_v6 ? i_s_tdata[350:287] : 64'd0;
        in_q.mlo      = in_v6 ? i_s_tdata[414:351] : {32'd0, i_s_tdata[382:351]};
        in_q.tag      = i_s_tdata[430:415];
    end

    // Slot memories
    assign id_wr = '{value: r_q.acct, expiry: r_q.ban_end, reason: r_q.tag,
                     order: r_stamp};
    assign ad_wr = '{family: r_q.v6, ahi: r_q.qhi, alo: r_q.qlo, mhi: r_q.mhi,
                     mlo: r_q.mlo, expiry: r_q.ban_end, reason: r_q.tag,
                     order: r_stamp};

    mabt_ram #(.WIDTH(ID_ENT_W), .DEPTH(ID_ENTRIES)) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (id_we),
        .i_waddr (r_pidx[ID_AW-1:0]),
        .i_wdata (id_wr),
        .i_raddr (r_idx[ID_AW-1:0]),
        .o_rdata (id_rd_w)
    );

    mabt_ram #(.WIDTH(AD_ENT_W), .DEPTH(ADDR_ENTRIES)) u_ad_ram (
        .i_clk   (i_clk),
        .i_we    (ad_we),
        .i_waddr (r_pidx[AD_AW-1:0]),
        .i_wdata (ad_wr),
        .i_raddr (r_idx[AD_AW-1:0]),
        .o_rdata (ad_rd_w)
    );

    assign id_rd = t_id_ent'(id_rd_w);
    assign ad_rd = t_ad_ent'(ad_rd_w);

    mabt_eval u_eval (
        .i_tab      (r_ptab),
        .i_q        (r_q),
        .i_id       (id_rd),
        .i_ad       (ad_rd),
        .i_stamp    (r_stamp),
        .i_best_age (r_best),
        .o_ev       (ev)
    );

    // Decide on the slot in the compare stage
    always_comb begin
        p_valid  = r_ptab ? r_adv[r_pidx[AD_AW-1:0]] : r_idv[r_pidx[ID_AW-1:0]];
        p_last   = (r_pidx == (r_ptab ? LAST_AD : LAST_ID)) &&
                   ((r_q.op != OP_SWEEP) || r_ptab);
        p_insert = 1'b0;
        p_remove = 1'b0;
        p_record = 1'b0;
        n_match  = r_match;
        case (r_q.op)
            OP_ADD_ID, OP_ADD_AD: p_insert = !p_valid;
            OP_LIFT_ID, OP_LIFT_AD: begin
                p_remove = p_valid && (ev.lift_hit || ev.stale);
                n_match  = r_match || (p_valid && ev.lift_hit);
            end
            OP_SWEEP: p_remove = p_valid && ev.stale;
            OP_QRY_ID, OP_QRY_AD:
                p_record = p_valid && ev.query_hit && !ev.stale &&
                           (!r_found || ev.older);
            default: ;
        endcase
        if (!r_pv) begin
            p_insert = 1'b0;
            p_remove = 1'b0;
            p_record = 1'b0;
            n_match  = r_match;
        end
        fin      = r_pv && (p_last || p_insert);
        n_rm     = (p_remove && (r_rm != 8'hFF)) ? r_rm + 8'd1 : r_rm;
        n_found  = r_found || p_record;
        n_best   = p_record ? r_stamp - (r_ptab ? ad_rd.order : id_rd.order) : r_best;
        n_until  = p_record ? (r_ptab ? ad_rd.expiry : id_rd.expiry) : r_until;
        n_reason = p_record ? (r_ptab ? ad_rd.reason : id_rd.reason) : r_reason;
        case (r_q.op)
            OP_ADD_ID, OP_ADD_AD:   n_status = p_insert ? ST_DONE : ST_FULL;
            OP_LIFT_ID, OP_LIFT_AD: n_status = n_match ? ST_DONE : ST_NOMATCH;
            OP_QRY_ID, OP_QRY_AD:   n_status = n_found ? ST_DONE : ST_NOMATCH;
            default:                n_status = ST_DONE;
        endcase
    end

    assign id_we = p_insert && !r_ptab;
    assign ad_we = p_insert && r_ptab;

    // Sequencer: issue one slot read a cycle, evaluate it the cycle after
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pv       <= 1'b0;
            r_iss_done <= 1'b0;
            r_idv      <= '0;
            r_adv      <= '0;
            r_stamp    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_q        <= in_q;
                        r_idx      <= '0;
                        r_tab      <= (in_op == OP_ADD_AD) || (in_op == OP_LIFT_AD) ||
                                      (in_op == OP_QRY_AD);
                        r_iss_done <= 1'b0;
                        r_pv       <= 1'b0;
                        r_rm       <= '0;
                        r_match    <= 1'b0;
                        r_found    <= 1'b0;
                        r_best     <= '0;
                        r_until    <= '0;
                        r_reason   <= '0;
                        if (in_op == OP_CLEAR) begin
                            r_idv      <= '0;
                            r_adv      <= '0;
                            r_o_status <= ST_DONE;
                            r_o_banned <= 1'b0;
                            r_o_until  <= '0;
                            r_o_reason <= '0;
                            r_o_rm     <= '0;
                            r_state    <= S_OUT;
                        end else begin
                            r_state    <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // Advance the read index, hopping tables on a sweep
                    if (!r_iss_done) begin
                        if (r_idx == (r_tab ? LAST_AD : LAST_ID)) begin
                            if ((r_q.op == OP_SWEEP) && !r_tab) begin
                                r_tab <= 1'b1;
                                r_idx <= '0;
                            end else begin
                                r_iss_done <= 1'b1;
                            end
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                    r_pv     <= !r_iss_done && !fin;
                    r_pidx   <= r_idx;
                    r_ptab   <= r_tab;
                    r_rm     <= n_rm;
                    r_match  <= n_match;
                    r_found  <= n_found;
                    r_best   <= n_best;
                    r_until  <= n_until;
                    r_reason <= n_reason;
                    // Update valid bits of the evaluated slot
                    if (p_insert || p_remove) begin
                        if (r_ptab) begin
                            r_adv[r_pidx[AD_AW-1:0]] <= p_insert;
                        end else begin
                            r_idv[r_pidx[ID_AW-1:0]] <= p_insert;
                        end
                    end
                    if (p_insert) begin
                        r_stamp <= r_stamp + 32'd1;
                    end
                    if (fin) begin
                        r_o_status <= n_status;
                        r_o_banned <= n_found;
                        r_o_until  <= n_until;
                        r_o_reason <= n_reason;
                        r_o_rm     <= n_rm;
                        r_state    <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_m_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = (r_state == S_OUT);
    assign o_m_tdata  = {5'd0, r_o_rm, r_o_reason, r_o_until, r_o_banned, r_o_status};

    // A result waiting on the output blocks new transfers
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready) else $error("input ready while result pending");

    // An accepted transfer always leaves the block busy in the cycle after
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready) else $error("ready right after accept");

    // Removed count only comes from lift or sweep
    a_rm_only_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (r_q.op != OP_LIFT_ID) && (r_q.op != OP_LIFT_AD) &&
         (r_q.op != OP_SWEEP)) |-> (r_o_rm == 8'd0)) else $error("stray removed count");

    // A ban hit always reports a done status
    a_banned_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_o_banned) |-> (r_o_status == ST_DONE)) else $error("hit without done");
endmodule
`default_nettype wire

// ===== rtl/core/mabt_ram.sv =====
`default_nettype none
module mabt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word, read one word registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/mabt_eval.sv =====
`default_nettype none
module mabt_eval (
    input  wire logic             i_tab,
    input  wire mabt_pkg::t_query i_q,
    input  wire mabt_pkg::t_id_ent i_id,
    input  wire mabt_pkg::t_ad_ent i_ad,
    input  wire logic [31:0]      i_stamp,
    input  wire logic [31:0]      i_best_age,
    output mabt_pkg::t_eval       o_ev
);
    import mabt_pkg::*;

    logic [63:0] exp_sel;
    logic [31:0] ord_sel;
    logic [31:0] age;
    logic        masked_eq;
    logic        fam_eq;

    // Pick the fields of the table under scan
    assign exp_sel = i_tab ? i_ad.expiry : i_id.expiry;
    assign ord_sel = i_tab ? i_ad.order  : i_id.order;

    // Masked address compare under the entry's mask
    assign masked_eq = ((i_q.qhi & i_ad.mhi) == (i_ad.ahi & i_ad.mhi)) &&
                       ((i_q.qlo & i_ad.mlo) == (i_ad.alo & i_ad.mlo));
    assign fam_eq    = (i_ad.family == i_q.v6);
    assign age       = i_stamp - ord_sel;

    always_comb begin
        o_ev.stale = (exp_sel != '1) &&
                     (exp_sel[63] || (exp_sel[62:0] < i_q.now));
        o_ev.older = (age > i_best_age);
        if (i_tab) begin
            o_ev.lift_hit  = fam_eq && (i_q.v6 ? masked_eq : (i_ad.alo == i_q.qlo));
            o_ev.query_hit = fam_eq && masked_eq;
        end else begin
            o_ev.lift_hit  = (i_id.value == i_q.acct);
            o_ev.query_hit = (i_id.value == i_q.acct);
        end
    end
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mabt_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int RANDOM_OPS  = 1800;
    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [63:0] PERMANENT = '1;

    typedef struct {
        t_op         op;
        logic [62:0] now;
        logic [63:0] ban_end;
        logic [31:0] acct;
        logic        v6;
        logic [63:0] qhi;
        logic [63:0] qlo;
        logic [63:0] mhi;
        logic [63:0] mlo;
        logic [15:0] tag;
    } ban_req_t;

    typedef struct {
        logic [1:0]  status;
        logic        banned;
        logic [63:0] hit_end;
        logic [15:0] reason;
        logic [7:0]  removed;
    } ban_verdict_t;

    // Shadow copy of both ban tables plus the queue of verdicts still owed
    class ban_verdict_board;
        bit          id_used [TABLE_DEPTH];
        logic [31:0] id_val  [TABLE_DEPTH];
        logic [63:0] id_end  [TABLE_DEPTH];
        logic [15:0] id_tag  [TABLE_DEPTH];
        logic [31:0] id_seq  [TABLE_DEPTH];
        bit          ad_used [TABLE_DEPTH];
        logic        ad_fam  [TABLE_DEPTH];
        logic [63:0] ad_h    [TABLE_DEPTH];
        logic [63:0] ad_l    [TABLE_DEPTH];
        logic [63:0] ad_mh   [TABLE_DEPTH];
        logic [63:0] ad_ml   [TABLE_DEPTH];
        logic [63:0] ad_end  [TABLE_DEPTH];
        logic [15:0] ad_tag  [TABLE_DEPTH];
        logic [31:0] ad_seq  [TABLE_DEPTH];
        logic [31:0] stamp;
        ban_verdict_t owed[$];
        int failures;

        function void clear_all();
            foreach (id_used[k]) id_used[k] = 0;
            foreach (ad_used[k]) ad_used[k] = 0;
        endfunction

        function bit expired(logic [63:0] end_t, logic [62:0] now);
            if (end_t == PERMANENT) return 0;
            if (end_t[63]) return 1;
            return end_t < {1'b0, now};
        endfunction

        function bit masked_eq(int k, logic [63:0] h, logic [63:0] l);
            return ((h & ad_mh[k]) == (ad_h[k] & ad_mh[k])) &&
                   ((l & ad_ml[k]) == (ad_l[k] & ad_ml[k]));
        endfunction

        // Work out the verdict of one accepted operation and update the tables
        function void note_request(ban_req_t r);
            ban_verdict_t v;
            logic [63:0] h, l, mh, ml;
            logic [31:0] age, best_age;
            int removed, matched;
            bit found, hit;
            h  = r.v6 ? r.qhi : 64'd0;
            l  = r.v6 ? r.qlo : {32'd0, r.qlo[31:0]};
            mh = r.v6 ? r.mhi : 64'd0;
            ml = r.v6 ? r.mlo : {32'd0, r.mlo[31:0]};
            v = '{ST_DONE, 1'b0, 64'd0, 16'd0, 8'd0};
            removed = 0; matched = 0; found = 0; best_age = 0;
            case (r.op)
                OP_ADD_ID: begin
                    v.status = ST_FULL;
                    for (int k = 0; k < TABLE_DEPTH; k++) begin
                        if (!id_used[k]) begin
                            id_used[k] = 1; id_val[k] = r.acct; id_end[k] = r.ban_end;
                            id_tag[k] = r.tag; id_seq[k] = stamp; stamp++;
                            v.status = ST_DONE;
                            break;
                        end
                    end
                end
                OP_ADD_AD: begin
                    v.status = ST_FULL;
                    for (int k = 0; k < TABLE_DEPTH; k++) begin
                        if (!ad_used[k]) begin
                            ad_used[k] = 1; ad_fam[k] = r.v6; ad_h[k] = h; ad_l[k] = l;
                            ad_mh[k] = mh; ad_ml[k] = ml; ad_end[k] = r.ban_end;
                            ad_tag[k] = r.tag; ad_seq[k] = stamp; stamp++;
                            v.status = ST_DONE;
                            break;
                        end
                    end
                end
                OP_LIFT_ID: begin
                    for (int k = 0; k < TABLE_DEPTH; k++) begin
                        if (!id_used[k]) continue;
                        if (id_val[k] == r.acct) begin
                            matched++; removed++; id_used[k] = 0;
                        end else if (expired(id_end[k], r.now)) begin
                            removed++; id_used[k] = 0;
                        end
                    end
                    v.status = matched ? ST_DONE : ST_NOMATCH;
                end
                OP_LIFT_AD: begin
                    for (int k = 0; k < TABLE_DEPTH; k++) begin
                        if (!ad_used[k]) continue;
                        if (ad_fam[k] != r.v6) hit = 0;
                        else if (r.v6) hit = masked_eq(k, h, l);
                        else hit = (ad_l[k] == l);
                        if (hit) begin
                            matched++; removed++; ad_used[k] = 0;
                        end else if (expired(ad_end[k], r.now)) begin
                            removed++; ad_used[k] = 0;
                        end
                    end
                    v.status = matched ? ST_DONE : ST_NOMATCH;
                end
                OP_SWEEP: begin
                    for (int k = 0; k < TABLE_DEPTH; k++) begin
                        if (id_used[k] && expired(id_end[k], r.now)) begin
                            id_used[k] = 0; removed++;
                        end
                        if (ad_used[k] && expired(ad_end[k], r.now)) begin
                            ad_used[k] = 0; removed++;
                        end
                    end
                end
                OP_QRY_ID, OP_QRY_AD: begin
                    for (int k = 0; k < TABLE_DEPTH; k++) begin
                        if (r.op == OP_QRY_ID) begin
                            if (!id_used[k] || id_val[k] != r.acct ||
                                expired(id_end[k], r.now)) continue;
                            age = stamp - id_seq[k];
                            if (!found || age > best_age) begin
                                found = 1; best_age = age;
                                v.hit_end = id_end[k]; v.reason = id_tag[k];
                            end
                        end else begin
                            if (!ad_used[k] || ad_fam[k] != r.v6 ||
                                expired(ad_end[k], r.now) || !masked_eq(k, h, l)) continue;
                            age = stamp - ad_seq[k];
                            if (!found || age > best_age) begin
                                found = 1; best_age = age;
                                v.hit_end = ad_end[k]; v.reason = ad_tag[k];
                            end
                        end
                    end
                    v.status = found ? ST_DONE : ST_NOMATCH;
                    v.banned = found;
                end
                default: clear_all();
            endcase
            v.removed = (removed > 255) ? 8'd255 : removed[7:0];
            owed.push_back(v);
        endfunction

        // Compare one result transfer with the oldest owed verdict
        function void check_verdict(logic [OUT_DATA_W-1:0] d);
            ban_verdict_t e;
            if (owed.size() == 0) begin
                $error("result with no operation pending: %h", d);
                failures++;
                return;
            end
            e = owed.pop_front();
            if (d[1:0] !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, d[1:0]); failures++;
            end
            if (d[2] !== e.banned) begin
                $error("banned: expected %0d, got %0d", e.banned, d[2]); failures++;
            end
            if (d[66:3] !== e.hit_end) begin
                $error("ban_until: expected %h, got %h", e.hit_end, d[66:3]); failures++;
            end
            if (d[82:67] !== e.reason) begin
                $error("hit_reason: expected %h, got %h", e.reason, d[82:67]); failures++;
            end
            if (d[90:83] !== e.removed) begin
                $error("removed_count: expected %0d, got %0d", e.removed, d[90:83]);
                failures++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic [IN_USER_W-1:0]  i_s_tuser = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    ban_verdict_board board = new();
    bit               hold_off_req = 0;
    bit               no_gaps = 0;
    int unsigned      cycles = 0;
    logic [62:0]      clock_base = 63'd1000;
    logic [31:0]      id_pool [6];
    logic [63:0]      ad_pool_h [6];
    logic [63:0]      ad_pool_l [6];

    masked_address_ban_table_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
    );

    always #1 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] prefix_mask(int bits);
        logic [127:0] m;
        m = ~(128'd0) << (128 - bits);
        return m[127:64];
    endfunction

    // Pick an end time around the running clock: permanent, soon, past or odd
    function automatic logic [63:0] pick_end(logic [62:0] now);
        case ($urandom_range(0, 9))
            0, 1: return PERMANENT;
            2: return (rand64() | 64'h8000_0000_0000_0000) & 64'hFFFF_FFFF_FFFF_FFFE;
            3: return rand64() >> 1;
            4: return {1'b0, now} - $urandom_range(1, 40);
            default: return {1'b0, now} + $urandom_range(0, 200);
        endcase
    endfunction

    // Build one operation drawing keys from small pools so that hits happen
    function automatic ban_req_t make_req(bit insert_only);
        ban_req_t r;
        int p, bits;
        clock_base = clock_base + $urandom_range(0, 6);
        p = $urandom_range(0, 5);
        r.now = ($urandom_range(0, 49) == 0) ? 63'(rand64()) : clock_base;
        r.ban_end = pick_end(r.now);
        r.acct = ($urandom_range(0, 9) == 0) ? $urandom : id_pool[p];
        r.v6 = p[0];
        r.qhi = ad_pool_h[p];
        r.qlo = ad_pool_l[p];
        if (!r.v6) begin
            r.qhi = rand64();
            r.qlo[63:32] = $urandom;
        end
        if ($urandom_range(0, 3) == 0) r.qlo[7:0] = 8'($urandom);
        bits = $urandom_range(0, 128);
        r.mhi = prefix_mask(bits);
        r.mlo = prefix_mask(bits > 64 ? bits - 64 : 0);
        if (!r.v6) r.mlo = {$urandom, 32'(prefix_mask($urandom_range(0, 32)) >> 32)};
        r.tag = 16'($urandom);
        if (insert_only) r.op = ($urandom_range(0, 1)) ? OP_ADD_ID : OP_ADD_AD;
        else case ($urandom_range(0, 99))
            0: r.op = OP_CLEAR;
            1, 2, 3, 4: r.op = OP_SWEEP;
            5, 6, 7, 8, 9, 10: r.op = OP_LIFT_ID;
            11, 12, 13, 14, 15, 16: r.op = OP_LIFT_AD;
            default: r.op = t_op'($urandom_range(0, 6) % 7);
        endcase
        // Noise: fully random fields
        if ($urandom_range(0, 9) == 0) begin
            r.now = 63'(rand64()); r.ban_end = rand64(); r.acct = $urandom;
            r.qhi = rand64(); r.qlo = rand64(); r.mhi = rand64(); r.mlo = rand64();
        end
        return r;
    endfunction

    // Offer one operation and hold it until the block takes it
    task automatic send_req(ban_req_t r);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {1'b0, r.tag, r.mlo, r.mhi, r.qlo, r.qhi, r.acct, r.ban_end, r.now};
        i_s_tuser <= {r.v6, r.op};
        do @(posedge i_clk); while (!o_s_tready);
        board.note_request(r);
    endtask

    // Result side: random stall per transfer, one long hold-off on request
    initial begin
        int stall;
        forever begin
            if (hold_off_req) begin
                i_m_tready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_off_req = 0;
            end
            stall = no_gaps ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            board.check_verdict(o_m_tdata);
        end
    end

    initial begin
        ban_req_t r;
        board.clear_all();
        board.stamp = 0;
        board.failures = 0;
        id_pool = '{32'd0, 32'hFFFF_FFFF, 32'd7, 32'hDEAD_BEEF, 32'd12345, 32'h8000_0000};
        foreach (ad_pool_h[k]) begin
            ad_pool_h[k] = rand64();
            ad_pool_l[k] = rand64();
        end
        ad_pool_h[0] = 64'd0; ad_pool_l[0] = 64'h0000_0000_C0A8_0101;
        ad_pool_h[1] = '1;    ad_pool_l[1] = '1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes of each field and every operation kind
        r = make_req(0);
        r.now = 63'd1000; r.v6 = 0; r.qhi = '1; r.qlo = 64'hFFFF_FFFF_0A00_0001;
        r.mhi = '1; r.mlo = '1;
        r.op = OP_ADD_ID; r.acct = '1; r.ban_end = PERMANENT; r.tag = '1; send_req(r);
        r.op = OP_ADD_ID; r.acct = '0; r.ban_end = 64'h8000_0000_0000_0000; r.tag = 0;
        send_req(r);
        r.op = OP_ADD_ID; r.acct = '1; r.ban_end = 64'h7FFF_FFFF_FFFF_FFFF; r.tag = 16'h55;
        send_req(r);
        r.op = OP_ADD_AD; r.ban_end = 64'd2000; send_req(r);
        r.op = OP_QRY_ID; r.acct = '1; send_req(r);
        r.op = OP_QRY_ID; r.acct = '0; send_req(r);
        r.op = OP_QRY_ID; r.acct = 32'd3; send_req(r);
        r.op = OP_QRY_AD; r.qlo = 64'h1234_5678_0A00_0001; send_req(r);
        r.op = OP_QRY_AD; r.now = 63'd2001; send_req(r);
        r.op = OP_ADD_AD; r.v6 = 1; r.qhi = '1; r.qlo = '0; r.mhi = '1; r.mlo = '0;
        r.ban_end = PERMANENT; r.tag = 16'hA5A5; send_req(r);
        r.op = OP_QRY_AD; r.qlo = 64'h1234; send_req(r);
        r.op = OP_LIFT_AD; r.v6 = 0; r.qlo = 64'h0A00_0001; r.mlo = '0; send_req(r);
        r.op = OP_LIFT_AD; r.v6 = 1; r.qhi = '1; r.qlo = '1; send_req(r);
        r.op = OP_LIFT_ID; r.acct = 32'd99; send_req(r);
        r.op = OP_LIFT_ID; r.acct = '1; send_req(r);
        r.op = OP_ADD_ID; r.acct = 32'd5; r.ban_end = 64'd10; send_req(r);
        r.op = OP_SWEEP; r.now = '1; send_req(r);
        r.op = OP_ADD_ID; r.ban_end = PERMANENT; send_req(r);
        r.op = OP_CLEAR; send_req(r);
        r.op = OP_QRY_ID; r.now = '0; send_req(r);
        r.op = OP_SWEEP; send_req(r);

        // Random: mostly table traffic, insert bursts fill the tables
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % 200 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            if (n == 600) hold_off_req = 1;
            if (n == 1200) begin
                // Drop valid while waiting so the last operation is not taken twice
                i_s_tvalid <= 1'b0;
                wait (board.owed.size() == 0);
            end
            send_req(make_req((n % 400) < 90));
        end
        i_s_tvalid <= 1'b0;

        wait (board.owed.size() == 0);
        repeat (200) @(posedge i_clk);
        if (board.failures == 0 && board.owed.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
